// ----- sv/max_heap_priority_queue_top_defines.svh -----
// shared assertion macros for the heap queue
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define MHPQ_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("heap queue check failed");

// condition that implies another in the next cycle
`define MHPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap queue sequence check failed");

`endif

// ----- sv/mhpq_pkg.sv -----
`default_nettype none

package mhpq_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD_INS,
    DP_LOAD_DEL,
    DP_TAKE_LAST,
    DP_READ_UP,
    DP_SWAP_UP,
    DP_READ_DN,
    DP_SWAP_DN,
    DP_PLACE
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    load_out;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_swap;
    logic dn_stop;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/mhpq_ram.sv -----
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- sv/mhpq_dp.sv -----
`default_nettype none
`include "max_heap_priority_queue_top_defines.svh"

module mhpq_dp #(
  parameter int CAPACITY = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mhpq_pkg::cmd_t                      cmd,
  output mhpq_pkg::sts_t                           sts,
  input  wire logic signed [mhpq_pkg::DATA_W-1:0]  value,
  output mhpq_pkg::status_t                        status,
  output logic signed [mhpq_pkg::DATA_W-1:0]       top_value,
  output logic        [mhpq_pkg::COUNT_W-1:0]      count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CHD_W = IDX_W + 2;

  logic        [CNT_W-1:0]           cnt;
  logic        [IDX_W-1:0]           pos;
  logic signed [mhpq_pkg::DATA_W-1:0] cur;
  logic signed [mhpq_pkg::DATA_W-1:0] top;

  logic        [IDX_W-1:0]           parent;
  logic        [CHD_W-1:0]           l_idx;
  logic        [CHD_W-1:0]           r_idx;
  logic        [CHD_W-1:0]           best_idx;
  logic                              l_gt;
  logic                              r_gt;
  logic signed [mhpq_pkg::DATA_W-1:0] best_val;

  logic                              we;
  logic        [IDX_W-1:0]           waddr;
  logic signed [mhpq_pkg::DATA_W-1:0] wdata;
  logic        [IDX_W-1:0]           raddr_a;
  logic        [IDX_W-1:0]           raddr_b;
  logic        [mhpq_pkg::DATA_W-1:0] rd_a_raw;
  logic        [mhpq_pkg::DATA_W-1:0] rd_b_raw;
  logic signed [mhpq_pkg::DATA_W-1:0] rdata_a;
  logic signed [mhpq_pkg::DATA_W-1:0] rdata_b;

  assign rdata_a = $signed(rd_a_raw);
  assign rdata_b = $signed(rd_b_raw);

  assign parent = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign l_idx  = CHD_W'({pos, 1'b1});
  assign r_idx  = CHD_W'({pos, 1'b0}) + CHD_W'(2);

  // children past the count take no part
  assign l_gt     = (l_idx < CHD_W'(cnt)) && (rdata_a > cur);
  assign r_gt     = (r_idx < CHD_W'(cnt)) && (rdata_b > (l_gt ? rdata_a : cur));
  assign best_idx = r_gt ? r_idx : l_idx;
  assign best_val = r_gt ? rdata_b : rdata_a;

  assign sts.full     = (cnt == CNT_W'(CAPACITY));
  assign sts.empty    = (cnt == '0);
  assign sts.pos_zero = (pos == '0);
  assign sts.up_swap  = (rdata_a < cur);
  assign sts.dn_stop  = !(l_gt || r_gt);

  always_comb begin
    we      = 1'b0;
    waddr   = pos;
    wdata   = cur;
    raddr_a = parent;
    raddr_b = r_idx[IDX_W-1:0];
    unique case (cmd.op)
      mhpq_pkg::DP_LOAD_DEL: raddr_a = IDX_W'(cnt - CNT_W'(1));
      mhpq_pkg::DP_READ_UP:  raddr_a = parent;
      mhpq_pkg::DP_READ_DN:  raddr_a = l_idx[IDX_W-1:0];
      mhpq_pkg::DP_SWAP_UP: begin
        we    = 1'b1;
        wdata = rdata_a;
      end
      mhpq_pkg::DP_SWAP_DN: begin
        we    = 1'b1;
        wdata = best_val;
      end
      mhpq_pkg::DP_PLACE:    we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case (cmd.op)
        mhpq_pkg::DP_LOAD_INS: cnt <= cnt + CNT_W'(1);
        mhpq_pkg::DP_LOAD_DEL: cnt <= cnt - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mhpq_pkg::DP_LOAD_INS: begin
        cur <= value;
        pos <= IDX_W'(cnt);
      end
      mhpq_pkg::DP_TAKE_LAST: begin
        cur <= rdata_a;
        pos <= '0;
      end
      mhpq_pkg::DP_SWAP_UP: pos <= parent;
      mhpq_pkg::DP_SWAP_DN: pos <= best_idx[IDX_W-1:0];
      default: ;
    endcase
    // root copy kept beside the memory
    if (we && waddr == '0) begin
      top <= wdata;
    end
    if (cmd.load_out) begin
      status    <= cmd.status;
      top_value <= sts.empty ? '0 : top;
      count     <= mhpq_pkg::COUNT_W'(cnt);
    end
  end

  mhpq_ram #(
    .WIDTH (mhpq_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a_raw),
    .raddr_b (raddr_b),
    .rdata_b (rd_b_raw)
  );

  `MHPQ_ASSERT(a_cnt_range, cnt <= CNT_W'(CAPACITY))
  `MHPQ_ASSERT(a_write_held, !we || (CNT_W'(waddr) < cnt))
  `MHPQ_ASSERT(a_del_nonempty, cmd.op != mhpq_pkg::DP_LOAD_DEL || cnt != '0)

endmodule

`default_nettype wire

// ----- sv/mhpq_ctrl.sv -----
`default_nettype none
`include "max_heap_priority_queue_top_defines.svh"

module mhpq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           kind,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mhpq_pkg::cmd_t      cmd,
  input  wire mhpq_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FIN
  } state_t;

  state_t             state;
  state_t             state_next;
  mhpq_pkg::status_t  stat;
  mhpq_pkg::status_t  stat_next;
  logic               out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    stat_next      = stat;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = mhpq_pkg::DP_NONE;
    cmd.load_out   = 1'b0;
    cmd.status     = stat;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          stat_next = mhpq_pkg::STAT_OK;
          if (kind == mhpq_pkg::KIND_DELETE) begin
            if (sts.empty) begin
              stat_next  = mhpq_pkg::STAT_EMPTY;
              state_next = ST_FIN;
            end else begin
              cmd.op     = mhpq_pkg::DP_LOAD_DEL;
              state_next = ST_DN_LAST;
            end
          end else if (sts.full) begin
            stat_next  = mhpq_pkg::STAT_FULL;
            state_next = ST_FIN;
          end else begin
            cmd.op     = mhpq_pkg::DP_LOAD_INS;
            state_next = ST_UP_RD;
          end
        end
      end
      ST_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.op     = mhpq_pkg::DP_PLACE;
          state_next = ST_FIN;
        end else begin
          cmd.op     = mhpq_pkg::DP_READ_UP;
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (sts.up_swap) begin
          cmd.op     = mhpq_pkg::DP_SWAP_UP;
          state_next = ST_UP_RD;
        end else begin
          cmd.op     = mhpq_pkg::DP_PLACE;
          state_next = ST_FIN;
        end
      end
      ST_DN_LAST: begin
        // last element becomes the moving key; nothing left if the count hit zero
        cmd.op     = mhpq_pkg::DP_TAKE_LAST;
        state_next = sts.empty ? ST_FIN : ST_DN_RD;
      end
      ST_DN_RD: begin
        cmd.op     = mhpq_pkg::DP_READ_DN;
        state_next = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (sts.dn_stop) begin
          cmd.op     = mhpq_pkg::DP_PLACE;
          state_next = ST_FIN;
        end else begin
          cmd.op     = mhpq_pkg::DP_SWAP_DN;
          state_next = ST_DN_RD;
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      stat      <= mhpq_pkg::STAT_OK;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      stat      <= stat_next;
    end
  end

  `MHPQ_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != ST_IDLE)
  `MHPQ_ASSERT_NEXT(a_load_shows_result, cmd.load_out, out_valid && state == ST_IDLE)

endmodule

`default_nettype wire

// ----- sv/max_heap_priority_queue_top.sv -----
// heap priority queue: one request in, one result out, one request at a time
// insert: climbs from the new leaf until it reaches the root or a parent not smaller than the key stops it
// delete: the last element takes the root and sinks; full and empty errors go straight to the result
// each level is a registered read then a compare and write
// a new request is taken only once the last is done; a result left waiting holds the next in its final state
// synchronous reset empties the queue; store contents are not cleared
`default_nettype none

module max_heap_priority_queue_top #(
  parameter int CAPACITY = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                kind,
  input  wire logic signed [mhpq_pkg::DATA_W-1:0]  value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic        [1:0]                        status,
  output logic signed [mhpq_pkg::DATA_W-1:0]       top_value,
  output logic        [mhpq_pkg::COUNT_W-1:0]      count
);

  mhpq_pkg::cmd_t    cmd;
  mhpq_pkg::sts_t    sts;
  mhpq_pkg::status_t status_q;

  assign status = status_q;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .status    (status_q),
    .top_value (top_value),
    .count     (count)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_CAP    = 128;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    mhpq_pkg::status_t                   status;
    logic signed [mhpq_pkg::DATA_W-1:0]  top_value;
    logic        [mhpq_pkg::COUNT_W-1:0] count;
  } heap_result_t;

  typedef struct {
    logic                               kind;
    logic signed [mhpq_pkg::DATA_W-1:0] value;
    bit                                 fixed;
    heap_result_t                       want;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic                               kind;
  logic signed [mhpq_pkg::DATA_W-1:0] value;
  logic                               out_valid;
  logic                               out_ready;
  logic        [1:0]                  status;
  logic signed [mhpq_pkg::DATA_W-1:0] top_value;
  logic        [mhpq_pkg::COUNT_W-1:0] count;

  // shadow copy of the heap
  logic signed [mhpq_pkg::DATA_W-1:0] shadow_keys [HEAP_CAP];
  int                                 shadow_count;

  heap_result_t pending_results [$];
  stim_row_t    directed_rows [$];
  int           fail_count;
  int           cycle_count;
  bit           idle_on;
  bit           long_hold_req;
  int           rx_stall_left;
  heap_result_t want_res;

  max_heap_priority_queue_top #(
    .CAPACITY (HEAP_CAP)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .top_value (top_value),
    .count     (count)
  );

  always #2 clk = ~clk;

  function automatic heap_result_t predict_heap_op(
      input logic k, input logic signed [mhpq_pkg::DATA_W-1:0] v);
    heap_result_t                       res;
    int                                 pos;
    int                                 parent;
    int                                 best;
    logic signed [mhpq_pkg::DATA_W-1:0] tmp;
    res.status = mhpq_pkg::STAT_OK;
    if (k == mhpq_pkg::KIND_INSERT) begin
      if (shadow_count >= HEAP_CAP) begin
        res.status = mhpq_pkg::STAT_FULL;
      end else begin
        pos = shadow_count;
        shadow_keys[pos] = v;
        // climb only past a strictly smaller parent
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (shadow_keys[parent] >= shadow_keys[pos]) break;
          tmp = shadow_keys[parent];
          shadow_keys[parent] = shadow_keys[pos];
          shadow_keys[pos] = tmp;
          pos = parent;
        end
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = mhpq_pkg::STAT_EMPTY;
      end else begin
        shadow_count--;
        shadow_keys[0] = shadow_keys[shadow_count];
        pos = 0;
        forever begin
          best = pos;
          // left child wins a tie, swap only with a strictly larger child
          if (2 * pos + 1 < shadow_count && shadow_keys[2 * pos + 1] > shadow_keys[best])
            best = 2 * pos + 1;
          if (2 * pos + 2 < shadow_count && shadow_keys[2 * pos + 2] > shadow_keys[best])
            best = 2 * pos + 2;
          if (best == pos) break;
          tmp = shadow_keys[pos];
          shadow_keys[pos] = shadow_keys[best];
          shadow_keys[best] = tmp;
          pos = best;
        end
      end
    end
    res.top_value = (shadow_count > 0) ? shadow_keys[0] : '0;
    res.count     = shadow_count[mhpq_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic logic signed [mhpq_pkg::DATA_W-1:0] random_key();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $signed($urandom_range(0, 8)) - 4;  // clusters of equal keys
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic flag_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  task automatic add_row(input logic k, input logic signed [mhpq_pkg::DATA_W-1:0] v,
                         input bit fx, input mhpq_pkg::status_t st,
                         input logic signed [mhpq_pkg::DATA_W-1:0] tv, input int cnt);
    stim_row_t row;
    row.kind  = k;
    row.value = v;
    row.fixed = fx;
    row.want.status    = st;
    row.want.top_value = tv;
    row.want.count     = cnt[mhpq_pkg::COUNT_W-1:0];
    directed_rows.push_back(row);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic k, input logic signed [mhpq_pkg::DATA_W-1:0] v,
                              input bit fx, input heap_result_t fixed_want);
    heap_result_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    pred = predict_heap_op(k, v);
    pending_results.push_back(fx ? fixed_want : pred);
    @(negedge clk);
  endtask

  task automatic send_random(input int insert_pct);
    send_request(($urandom_range(0, 99) < insert_pct) ? mhpq_pkg::KIND_INSERT
                                                      : mhpq_pkg::KIND_DELETE,
                 random_key(), 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // receiver side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      rx_stall_left--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_stall_left = LONG_HOLD;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(1, 17);
    end
    out_ready <= (rx_stall_left == 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_failure($sformatf("unexpected result: status %0d top %0d count %0d",
                               status, top_value, count));
      end else begin
        want_res = pending_results.pop_front();
        if (status !== want_res.status || top_value !== want_res.top_value ||
            count !== want_res.count)
          flag_failure($sformatf(
            "mismatch: status %0d/%0d top %0d/%0d count %0d/%0d (expected/actual)",
            want_res.status, status, want_res.top_value, top_value,
            want_res.count, count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = mhpq_pkg::KIND_INSERT;
    value         = '0;
    out_ready     = 1'b0;
    shadow_count  = 0;
    fail_count    = 0;
    cycle_count   = 0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    rx_stall_left = 0;

    // after reset, extremes, empty errors, equal keys
    add_row(mhpq_pkg::KIND_DELETE, 0, 1, mhpq_pkg::STAT_EMPTY, 0, 0);
    add_row(mhpq_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 1, mhpq_pkg::STAT_OK, 32'sh7FFF_FFFF, 1);
    add_row(mhpq_pkg::KIND_INSERT, 32'sh8000_0000, 1, mhpq_pkg::STAT_OK, 32'sh7FFF_FFFF, 2);
    add_row(mhpq_pkg::KIND_DELETE, 32'sh7FFF_FFFF, 1, mhpq_pkg::STAT_OK, 32'sh8000_0000, 1);
    add_row(mhpq_pkg::KIND_DELETE, 0, 1, mhpq_pkg::STAT_OK, 0, 0);
    add_row(mhpq_pkg::KIND_DELETE, -1, 1, mhpq_pkg::STAT_EMPTY, 0, 0);
    add_row(mhpq_pkg::KIND_INSERT, -1, 1, mhpq_pkg::STAT_OK, -1, 1);
    add_row(mhpq_pkg::KIND_INSERT, 0, 1, mhpq_pkg::STAT_OK, 0, 2);
    add_row(mhpq_pkg::KIND_INSERT, 0, 0, mhpq_pkg::STAT_OK, 0, 0);
    add_row(mhpq_pkg::KIND_INSERT, 5, 0, mhpq_pkg::STAT_OK, 0, 0);
    add_row(mhpq_pkg::KIND_INSERT, 5, 0, mhpq_pkg::STAT_OK, 0, 0);
    add_row(mhpq_pkg::KIND_INSERT, -7, 0, mhpq_pkg::STAT_OK, 0, 0);
    add_row(mhpq_pkg::KIND_INSERT, 1000, 0, mhpq_pkg::STAT_OK, 0, 0);
    add_row(mhpq_pkg::KIND_INSERT, 5, 0, mhpq_pkg::STAT_OK, 0, 0);
    repeat (5) add_row(mhpq_pkg::KIND_DELETE, 32'sh5555_5555, 0, mhpq_pkg::STAT_OK, 0, 0);
    add_row(mhpq_pkg::KIND_INSERT, 32'sh5555_5555, 0, mhpq_pkg::STAT_OK, 0, 0);
    add_row(mhpq_pkg::KIND_INSERT, 32'shAAAA_AAAA, 0, mhpq_pkg::STAT_OK, 0, 0);
    repeat (4) add_row(mhpq_pkg::KIND_DELETE, 0, 0, mhpq_pkg::STAT_OK, 0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].value,
                   directed_rows[i].fixed, directed_rows[i].want);

    // mixed traffic, with the receiver holding off for a long stretch
    for (int n = 0; n < 300; n++) begin
      if (n == 100) long_hold_req = 1'b1;
      send_random(60);
    end
    drain_results();

    // fill up, then push against the full heap
    while (shadow_count < HEAP_CAP)
      send_request(mhpq_pkg::KIND_INSERT, random_key(), 1'b0, '0);
    repeat (10) send_request(mhpq_pkg::KIND_INSERT, random_key(), 1'b0, '0);
    repeat (3) begin
      send_request(mhpq_pkg::KIND_DELETE, random_key(), 1'b0, '0);
      send_request(mhpq_pkg::KIND_INSERT, random_key(), 1'b0, '0);
      send_request(mhpq_pkg::KIND_INSERT, random_key(), 1'b0, '0);
    end

    // drain to empty and beyond
    while (shadow_count > 0) send_request(mhpq_pkg::KIND_DELETE, random_key(), 1'b0, '0);
    repeat (5) send_request(mhpq_pkg::KIND_DELETE, random_key(), 1'b0, '0);

    repeat (300) send_random(50);

    // closing stretch runs back to back
    idle_on = 1'b0;
    repeat (200) send_random(55);

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mhpq_pkg.sv
sv/mhpq_ram.sv
sv/mhpq_dp.sv
sv/mhpq_ctrl.sv
sv/max_heap_priority_queue_top.sv
tb/sv/tb_top.sv
